[hw/rtl/hweq_pkg.sv]
// shared constants and command codes for the histogram equalizer
package hweq_pkg;

   localparam int PIXEL_BITS_DEFAULT = 8;
   localparam int COUNT_LOG2_DEFAULT = 24;

   localparam int LEVEL_W = 16;
   localparam int CMD_W   = 2;

   localparam logic [LEVEL_W-1:0] OUT_MAX_RESET = 16'd255;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BUILD = 2'd2;
   localparam logic [CMD_W-1:0] CMD_MAP   = 2'd3;

endpackage

[hw/rtl/hweq_ram.sv]
// generic single-write, single-read ram with registered read
module hweq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/hweq_level_calc.sv]
// equalized level unit: registered multiply, then one quotient bit per cycle
module hweq_level_calc #(
   parameter int COUNT_W = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hweq_pkg::LEVEL_W-1:0] out_max,
   input  logic [COUNT_W-1:0]          cum,
   input  logic [COUNT_W-1:0]          total,
   output logic                        done,
   output logic [hweq_pkg::LEVEL_W-1:0] level
);

   localparam int LW     = hweq_pkg::LEVEL_W;
   localparam int PW     = LW + COUNT_W;
   localparam int STEP_W = $clog2(LW);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LW - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PW-1:0]     rem_ff, rem_in;
   logic [PW-1:0]     dsh_ff, dsh_in;
   logic [LW-1:0]     quo_ff, quo_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = PW'(out_max) * PW'(cum);
         dsh_in  = PW'(total) << (LW - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[LW-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[LW-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
   end

   assign done  = done_ff;
   assign level = quo_ff;

endmodule

[hw/rtl/histogram_equalizer.sv]
// histogram equalizer top level: command decode, histogram and level table memories
//
// items enter on req_valid/req_ready with req_cmd and req_pixel; results leave on
// rsp_valid/rsp_ready with rsp_level and rsp_count_saturated, one per map item only.
// count items do a read-modify-write of the bin memory with forwarding, so a count item
// is taken every cycle while req_ready is high; map items read the level table and their
// result is registered into the output buffer after the table read, one map per cycle
// while the receiver keeps up.
// a clear item zeroes the bins one entry a cycle, with req_ready low until all are zero.
// a build item walks every bin; each level takes a memory read, an accumulate, a
// registered multiply and a 16-step restoring divide.
// after reset both memories are swept to zero with req_ready low; out_max resets to 255
// and is written through csr_wr_en/csr_wr_data, by the user only while idle; the block
// does not enforce this. when the receiver stalls, a two-entry output buffer fills; count
// and clear items are still taken while it has room, and req_ready drops once it is full.
module histogram_equalizer #(
   parameter int PIXEL_BITS = hweq_pkg::PIXEL_BITS_DEFAULT,
   parameter int COUNT_LOG2 = hweq_pkg::COUNT_LOG2_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [hweq_pkg::CMD_W-1:0]   req_cmd,
   input  logic [PIXEL_BITS-1:0]        req_pixel,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hweq_pkg::LEVEL_W-1:0] rsp_level,
   output logic                         rsp_count_saturated,
   input  logic                         csr_wr_en,
   input  logic [hweq_pkg::LEVEL_W-1:0] csr_wr_data
);

   localparam int CW    = COUNT_LOG2 + 1;
   localparam int LW    = hweq_pkg::LEVEL_W;
   localparam int DEPTH = 1 << PIXEL_BITS;
   localparam logic [PIXEL_BITS-1:0] WALK_LAST = {PIXEL_BITS{1'b1}};

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CLEAR  = 3'd2;
   localparam logic [2:0] ST_BREAD  = 3'd3;
   localparam logic [2:0] ST_BACC   = 3'd4;
   localparam logic [2:0] ST_BSTART = 3'd5;
   localparam logic [2:0] ST_BWAIT  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [PIXEL_BITS-1:0] walk_ff, walk_in;
   logic [CW-1:0]         cum_ff, cum_in;
   logic [CW-1:0]         total_ff, total_in;
   logic                  sat_ff, sat_in;
   logic [LW-1:0]         out_max_ff, out_max_in;

   logic                  s1_cnt_ff, s1_cnt_in;
   logic                  s1_map_ff, s1_map_in;
   logic [PIXEL_BITS-1:0] s1_addr_ff, s1_addr_in;
   logic                  s1_sat_ff, s1_sat_in;

   logic                  fwd_v_ff, fwd_v_in;
   logic [PIXEL_BITS-1:0] fwd_addr_ff, fwd_addr_in;
   logic [CW-1:0]         fwd_data_ff, fwd_data_in;

   logic                  head_v_ff, head_v_in;
   logic [LW-1:0]         head_level_ff, head_level_in;
   logic                  head_sat_ff, head_sat_in;
   logic                  tail_v_ff, tail_v_in;
   logic [LW-1:0]         tail_level_ff, tail_level_in;
   logic                  tail_sat_ff, tail_sat_in;

   logic                  bin_we;
   logic [PIXEL_BITS-1:0] bin_waddr;
   logic [CW-1:0]         bin_wdata;
   logic [PIXEL_BITS-1:0] bin_raddr;
   logic [CW-1:0]         bin_rdata;

   logic                  tab_we;
   logic [PIXEL_BITS-1:0] tab_waddr;
   logic [LW-1:0]         tab_wdata;
   logic [LW-1:0]         tab_rdata;

   logic                  calc_start;
   logic                  calc_done;
   logic [LW-1:0]         calc_level;

   logic                  accept;
   logic                  pop;
   logic [1:0]            occupancy;
   logic [CW-1:0]         count_base;
   logic [CW-1:0]         count_next;

   hweq_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_waddr),
      .wr_data (bin_wdata),
      .rd_addr (bin_raddr),
      .rd_data (bin_rdata)
   );

   hweq_ram #(
      .WIDTH (LW),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (req_pixel),
      .rd_data (tab_rdata)
   );

   hweq_level_calc #(
      .COUNT_W (CW)
   ) u_level_calc (
      .clock   (clock),
      .reset   (reset),
      .start   (calc_start),
      .out_max (out_max_ff),
      .cum     (cum_ff),
      .total   (total_ff),
      .done    (calc_done),
      .level   (calc_level)
   );

   assign pop       = head_v_ff && rsp_ready;
   assign occupancy = {1'b0, head_v_ff} + {1'b0, tail_v_ff} + {1'b0, s1_map_ff}
                      - {1'b0, pop};
   assign req_ready = (state_ff == ST_IDLE) && (occupancy < 2'd2);
   assign accept    = req_valid && req_ready;

   // bypass the write of the previous cycle, which the ram read did not see yet
   assign count_base = (fwd_v_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : bin_rdata;
   assign count_next = count_base + CW'(1);

   always_comb begin
      bin_we    = 1'b0;
      bin_waddr = s1_addr_ff;
      bin_wdata = count_next;
      if ((state_ff == ST_INIT) || (state_ff == ST_CLEAR)) begin
         bin_we    = 1'b1;
         bin_waddr = walk_ff;
         bin_wdata = '0;
      end else if (s1_cnt_ff) begin
         bin_we = 1'b1;
      end
   end

   assign bin_raddr = (state_ff == ST_IDLE) ? req_pixel : walk_ff;

   always_comb begin
      tab_we    = 1'b0;
      tab_waddr = walk_ff;
      tab_wdata = '0;
      if (state_ff == ST_INIT) begin
         tab_we = 1'b1;
      end else if ((state_ff == ST_BWAIT) && calc_done) begin
         tab_we    = 1'b1;
         tab_wdata = (total_ff == '0) ? '0 : calc_level;
      end
   end

   always_comb begin
      state_in   = state_ff;
      walk_in    = walk_ff;
      cum_in     = cum_ff;
      total_in   = total_ff;
      sat_in     = sat_ff;
      out_max_in = csr_wr_en ? csr_wr_data : out_max_ff;
      s1_cnt_in  = 1'b0;
      s1_map_in  = 1'b0;
      s1_addr_in = req_pixel;
      s1_sat_in  = sat_ff;
      calc_start = 1'b0;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            walk_in = walk_ff + PIXEL_BITS'(1);
            if (walk_ff == WALK_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  hweq_pkg::CMD_CLEAR: begin
                     total_in = '0;
                     sat_in   = 1'b0;
                     walk_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  hweq_pkg::CMD_COUNT: begin
                     if (total_ff[COUNT_LOG2]) begin
                        sat_in = 1'b1;
                     end else begin
                        total_in  = total_ff + CW'(1);
                        s1_cnt_in = 1'b1;
                     end
                  end
                  hweq_pkg::CMD_BUILD: begin
                     walk_in  = '0;
                     cum_in   = '0;
                     state_in = ST_BREAD;
                  end
                  hweq_pkg::CMD_MAP: begin
                     s1_map_in = 1'b1;
                  end
               endcase
            end
         end
         ST_BREAD: begin
            state_in = ST_BACC;
         end
         ST_BACC: begin
            cum_in   = cum_ff + bin_rdata;
            state_in = ST_BSTART;
         end
         ST_BSTART: begin
            calc_start = 1'b1;
            state_in   = ST_BWAIT;
         end
         ST_BWAIT: begin
            if (calc_done) begin
               walk_in = walk_ff + PIXEL_BITS'(1);
               if (walk_ff == WALK_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_BREAD;
               end
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign fwd_v_in    = s1_cnt_ff;
   assign fwd_addr_in = s1_addr_ff;
   assign fwd_data_in = count_next;

   // two-entry output buffer, head drives the result port
   always_comb begin
      head_v_in     = head_v_ff;
      head_level_in = head_level_ff;
      head_sat_in   = head_sat_ff;
      tail_v_in     = tail_v_ff;
      tail_level_in = tail_level_ff;
      tail_sat_in   = tail_sat_ff;
      if (pop) begin
         if (tail_v_ff) begin
            head_level_in = tail_level_ff;
            head_sat_in   = tail_sat_ff;
            tail_v_in     = s1_map_ff;
            tail_level_in = tab_rdata;
            tail_sat_in   = s1_sat_ff;
         end else begin
            head_v_in     = s1_map_ff;
            head_level_in = tab_rdata;
            head_sat_in   = s1_sat_ff;
         end
      end else if (s1_map_ff) begin
         if (!head_v_ff) begin
            head_v_in     = 1'b1;
            head_level_in = tab_rdata;
            head_sat_in   = s1_sat_ff;
         end else begin
            tail_v_in     = 1'b1;
            tail_level_in = tab_rdata;
            tail_sat_in   = s1_sat_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         walk_ff    <= '0;
         total_ff   <= '0;
         sat_ff     <= 1'b0;
         out_max_ff <= hweq_pkg::OUT_MAX_RESET;
         s1_cnt_ff  <= 1'b0;
         s1_map_ff  <= 1'b0;
         fwd_v_ff   <= 1'b0;
         head_v_ff  <= 1'b0;
         tail_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         walk_ff    <= walk_in;
         total_ff   <= total_in;
         sat_ff     <= sat_in;
         out_max_ff <= out_max_in;
         s1_cnt_ff  <= s1_cnt_in;
         s1_map_ff  <= s1_map_in;
         fwd_v_ff   <= fwd_v_in;
         head_v_ff  <= head_v_in;
         tail_v_ff  <= tail_v_in;
      end
      cum_ff        <= cum_in;
      s1_addr_ff    <= s1_addr_in;
      s1_sat_ff     <= s1_sat_in;
      fwd_addr_ff   <= fwd_addr_in;
      fwd_data_ff   <= fwd_data_in;
      head_level_ff <= head_level_in;
      head_sat_ff   <= head_sat_in;
      tail_level_ff <= tail_level_in;
      tail_sat_ff   <= tail_sat_in;
   end

   assign rsp_valid           = head_v_ff;
   assign rsp_level           = head_level_ff;
   assign rsp_count_saturated = head_sat_ff;

endmodule
